// File: rtl/hslp_pkg.sv
// Shared types and constants for the HTTP status line parser.
`timescale 1ns / 1ps

package hslp_pkg;

  // Character codes
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Parse phases
  localparam logic [2:0] PH_VERSION = 3'd0;
  localparam logic [2:0] PH_BLANK1  = 3'd1;
  localparam logic [2:0] PH_CODE    = 3'd2;
  localparam logic [2:0] PH_BLANK2  = 3'd3;
  localparam logic [2:0] PH_REASON  = 3'd4;
  localparam logic [2:0] PH_LF      = 3'd5;
  localparam logic [2:0] PH_IDLE    = 3'd6;

  // Byte roles
  localparam logic [2:0] ROLE_SEP     = 3'd0;
  localparam logic [2:0] ROLE_VERSION = 3'd1;
  localparam logic [2:0] ROLE_CODE    = 3'd2;
  localparam logic [2:0] ROLE_REASON  = 3'd3;
  localparam logic [2:0] ROLE_END     = 3'd4;

  localparam logic [2:0] CODE_DIGITS  = 3'd3;
  localparam logic [2:0] CODE_LEN_MAX = 3'd7;

  // Parser state carried from word to word
  typedef struct packed {
    logic [2:0] phase;
    logic [2:0] code_len;
    logic       code_bad;
    logic [9:0] code_value;
    logic       token_seen;
  } parse_state_t;

  // Result of one word
  typedef struct packed {
    logic [7:0] byte_echo;
    logic [2:0] role;
    logic       line_done;
    logic       line_ok;
    logic [9:0] status_code;
  } parse_result_t;

  localparam parse_state_t STATE_RESET = '{
    phase:      PH_VERSION,
    code_len:   3'd0,
    code_bad:   1'b0,
    code_value: 10'd0,
    token_seen: 1'b0
  };

endpackage

// File: rtl/http_status_line_parser.sv
// Path: each input word is held in the input register, then its result in the result
// register; a stall at the output holds the result register and, once full, the input register.
// Throughput: one byte per cycle unless out_tready holds the result; the parse step
// between the two registers is a single pass of the phase machine in hslp_core.
// Reset (rst_n low, synchronous): both stages empty, parse state back to
// expecting the first byte of the version token.
`timescale 1ns / 1ps

module http_status_line_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [0:0]  in_tuser,   // [0] line_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] byte_echo, [17:8] status_code, [23:18] zero
  output logic [3:0]  out_tuser,  // [2:0] role, [3] line_ok
  output logic        out_tlast   // line_done
);
  import hslp_pkg::*;

  logic          in_valid_r;
  logic [7:0]    in_byte_r;
  logic          in_start_r;
  logic          out_valid_r;
  parse_result_t out_res_r;
  parse_state_t  state_r;
  parse_state_t  state_nxt;
  parse_result_t res_nxt;
  logic          out_load;
  logic          step;

  // Stage handshakes
  assign out_load  = !out_valid_r || out_tready;
  assign step      = in_valid_r && out_load;
  assign in_tready = !in_valid_r || step;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      in_byte_r  <= in_tdata;
      in_start_r <= in_tuser[0];
    end
  end

  hslp_core u_core (
    .data_byte  (in_byte_r),
    .line_start (in_start_r),
    .state_cur  (state_r),
    .state_nxt  (state_nxt),
    .result     (res_nxt)
  );

  // Parse state advances once per word moved to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (step) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= in_valid_r;
    end
    if (step) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r.status_code, out_res_r.byte_echo};
  assign out_tuser  = {out_res_r.line_ok, out_res_r.role};
  assign out_tlast  = out_res_r.line_done;

endmodule

// File: rtl/hslp_core.sv
// Combinational parse step: one byte and the current state in, result and next state out.
`timescale 1ns / 1ps

module hslp_core (
  input  logic [7:0]            data_byte,
  input  logic                  line_start,
  input  hslp_pkg::parse_state_t state_cur,
  output hslp_pkg::parse_state_t state_nxt,
  output hslp_pkg::parse_result_t result
);
  import hslp_pkg::*;

  parse_state_t st;
  parse_state_t nx;
  logic         is_blank;
  logic         is_digit;
  logic         fail;
  logic [2:0]   role;
  logic         done;
  logic         ok;
  logic [9:0]   code;
  logic [9:0]   digit_val;
  logic [9:0]   value_x10;

  // Character classes
  assign is_blank  = (data_byte == CH_SPACE) || (data_byte == CH_TAB);
  assign is_digit  = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
  assign digit_val = {6'd0, data_byte[3:0]};

  // A line start restarts the parse before the byte is handled
  assign st        = line_start ? STATE_RESET : state_cur;
  assign value_x10 = {st.code_value[6:0], 3'b000} + {st.code_value[8:0], 1'b0};

  always_comb begin
    nx   = st;
    role = ROLE_SEP;
    done = 1'b0;
    ok   = 1'b0;
    code = 10'd0;
    fail = 1'b0;

    unique case (st.phase)
      PH_VERSION: begin
        if (data_byte == CH_LF) begin
          role = ROLE_END;
          fail = 1'b1;
        end else if (is_blank) begin
          if (st.token_seen) nx.phase = PH_BLANK1;
          else fail = 1'b1;
        end else begin
          role          = ROLE_VERSION;
          nx.token_seen = 1'b1;
        end
      end
      PH_BLANK1, PH_CODE: begin
        if (data_byte == CH_LF) begin
          role = ROLE_END;
          fail = 1'b1;
        end else if (is_blank) begin
          if (st.phase == PH_CODE) begin
            if (st.code_len == CODE_DIGITS && !st.code_bad) nx.phase = PH_BLANK2;
            else fail = 1'b1;
          end
        end else begin
          // code token byte: accumulate first three digits
          role     = ROLE_CODE;
          nx.phase = PH_CODE;
          if (!is_digit) nx.code_bad = 1'b1;
          else if (st.code_len < CODE_DIGITS) nx.code_value = value_x10 + digit_val;
          if (st.code_len < CODE_LEN_MAX) nx.code_len = st.code_len + 3'd1;
        end
      end
      PH_BLANK2: begin
        if (data_byte == CH_LF) begin
          role = ROLE_END;
          fail = 1'b1;
        end else if (data_byte == CH_CR) begin
          fail = 1'b1;
        end else if (!is_blank) begin
          role     = ROLE_REASON;
          nx.phase = PH_REASON;
        end
      end
      PH_REASON: begin
        if (data_byte == CH_LF) begin
          role = ROLE_END;
          fail = 1'b1;
        end else if (data_byte == CH_CR) begin
          role     = ROLE_END;
          nx.phase = PH_LF;
        end else begin
          role = ROLE_REASON;
        end
      end
      PH_LF: begin
        if (data_byte == CH_LF) begin
          role     = ROLE_END;
          done     = 1'b1;
          ok       = 1'b1;
          code     = st.code_value;
          nx.phase = PH_IDLE;
        end else begin
          fail = 1'b1;
        end
      end
      default: begin
        // line finished: ignore until next line start
      end
    endcase

    if (fail) begin
      done     = 1'b1;
      ok       = 1'b0;
      code     = 10'd0;
      nx.phase = PH_IDLE;
    end
  end

  assign state_nxt          = nx;
  assign result.byte_echo   = data_byte;
  assign result.role        = role;
  assign result.line_done   = done;
  assign result.line_ok     = ok;
  assign result.status_code = code;

endmodule
